>>> src/u16u8_pkg.sv
`default_nettype none
package u16u8_pkg;

  localparam int MAX_STRING_UNITS = 65535;

  localparam int UNIT_W  = 16;
  localparam int CAP_W   = 16;
  localparam int LEN_W   = 18;
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int CP_W    = 21;
  // Worst case per transaction: two three-byte characters plus the final item
  localparam int BUF_BYTES = 7;
  localparam int CNT_W     = 3;

  localparam logic [LEN_W:0] LEN_MAX = (LEN_W + 1)'(3 * MAX_STRING_UNITS);
  localparam logic [CP_W-1:0] REPL_CP = 21'h0FFFD;

  typedef enum logic [0:0] {
    CFG_CAPACITY = 1'b0,
    CFG_STOP_NUL = 1'b1
  } cfg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA   = 2'd0,
    KIND_TERM   = 2'd1,
    KIND_NOROOM = 2'd2
  } kind_e;

  // Results of one decoded unit, handed to the output buffer
  typedef struct packed {
    logic                        load;
    logic [BUF_BYTES*BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]            cnt;
    logic                        fin;
    kind_e                       kind;
    logic [LEN_W-1:0]            need;
  } load_t;

endpackage
`default_nettype wire

>>> src/u16u8_if.sv
`default_nettype none
interface u16u8_in_if;
  import u16u8_pkg::*;
  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] code_unit;
  logic              end_of_input;

  modport source (output valid, code_unit, end_of_input, input ready);
  modport sink   (input valid, code_unit, end_of_input, output ready);
endinterface

interface u16u8_out_if;
  import u16u8_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [KIND_W-1:0] item_kind;
  logic [LEN_W-1:0]  needed_length;
  logic              run_last;

  modport source (output valid, out_byte, item_kind, needed_length, run_last, input ready);
  modport sink   (input valid, out_byte, item_kind, needed_length, run_last, output ready);
endinterface
`default_nettype wire

>>> src/u16u8_core.sv
`default_nettype none
module u16u8_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [u16u8_pkg::CAP_W-1:0] cfg_wdata_i,
  u16u8_in_if.sink                    unit_i,
  input  logic                        can_load_i,
  output u16u8_pkg::load_t            ld_o
);
  import u16u8_pkg::*;

  typedef struct packed {
    logic [CAP_W-1:0]            room;
    logic [LEN_W-1:0]            len;
    logic [BUF_BYTES*BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]            cnt;
  } acc_t;

  function automatic logic is_high(logic [UNIT_W-1:0] u);
    return (u >= 16'hD800) && (u <= 16'hDBFF);
  endfunction

  function automatic logic is_low(logic [UNIT_W-1:0] u);
    return (u >= 16'hDC00) && (u <= 16'hDFFF);
  endfunction

  function automatic logic [UNIT_W-1:0] map_bmp(logic [UNIT_W-1:0] u);
    logic [UNIT_W-1:0] r;
    r = u;
    if (is_low(u) || (&u[15:1]) || ((u >= 16'hFDD0) && (u <= 16'hFDEF))) begin
      r = REPL_CP[UNIT_W-1:0];
    end
    return r;
  endfunction

  // Encode one character; skip it and mark the destination full when it does not fit
  function automatic acc_t put_char(acc_t a, logic [CP_W-1:0] c);
    acc_t        r;
    logic [2:0]  l;
    logic [31:0] d;
    logic [LEN_W:0] s;
    r = a;
    if (c < 21'h80) begin
      l = 3'd1;
      d = {24'b0, c[7:0]};
    end else if (c < 21'h800) begin
      l = 3'd2;
      d = {16'b0, 2'b10, c[5:0], 3'b110, c[10:6]};
    end else if (c < 21'h10000) begin
      l = 3'd3;
      d = {8'b0, 2'b10, c[5:0], 2'b10, c[11:6], 4'b1110, c[15:12]};
    end else begin
      l = 3'd4;
      d = {2'b10, c[5:0], 2'b10, c[11:6], 2'b10, c[17:12], 5'b11110, c[20:18]};
    end
    if (({14'b0, l} + 17'd1) <= {1'b0, a.room}) begin
      r.bytes = a.bytes | ((BUF_BYTES*BYTE_W)'(d) << {a.cnt, 3'b000});
      r.cnt   = a.cnt + l;
      r.room  = a.room - {13'b0, l};
    end else if (a.room > 16'd1) begin
      r.room = 16'd1;
    end
    s = {1'b0, a.len} + {16'b0, l};
    r.len = (s > LEN_MAX) ? LEN_MAX[LEN_W-1:0] : s[LEN_W-1:0];
    return r;
  endfunction

  logic [CAP_W-1:0]  cap_q;
  logic              nul_q;
  logic              in_valid_q;
  logic [UNIT_W-1:0] unit_q;
  logic              eoi_q;
  logic [CAP_W-1:0]  room_q;
  logic [LEN_W-1:0]  len_q;
  logic              hv_q;
  logic [9:0]        hh_q;
  logic              halted_q;
  logic              active_q;

  logic              advance;
  acc_t              acc;
  logic              hv_d;
  logic [9:0]        hh_d;
  logic              halted_d;
  logic              active_d;
  logic              fresh;
  logic              ended;
  logic              fin;
  kind_e             kind;
  logic [LEN_W-1:0]  need;
  logic [CP_W-1:0]   cp;
  logic [UNIT_W-1:0] bmp;

  assign unit_i.ready = !in_valid_q || can_load_i;
  assign advance      = in_valid_q && can_load_i;

  always_comb begin
    acc      = '{room: cap_q, len: '0, bytes: '0, cnt: '0};
    hv_d     = 1'b0;
    hh_d     = hh_q;
    halted_d = halted_q;
    active_d = active_q;
    fresh    = 1'b1;
    ended    = 1'b0;
    fin      = 1'b0;
    kind     = KIND_DATA;
    need     = '0;
    cp       = '0;
    bmp      = '0;
    if (active_q) begin
      acc.room = room_q;
      acc.len  = len_q;
      hv_d     = hv_q;
    end
    if (halted_q) begin
      // drop units until the string closes
      if (eoi_q) halted_d = 1'b0;
    end else begin
      active_d = 1'b1;
      if (hv_d) begin
        hv_d = 1'b0;
        if (is_low(unit_q)) begin
          cp = 21'h10000 + {1'b0, hh_q, unit_q[9:0]};
          if (&cp[15:1]) cp = REPL_CP;
          fresh = 1'b0;
        end else begin
          cp = REPL_CP;
        end
        acc = put_char(acc, cp);
      end
      if (fresh) begin
        if (is_high(unit_q)) begin
          hv_d = 1'b1;
          hh_d = unit_q[9:0];
        end else begin
          bmp = map_bmp(unit_q);
          if (nul_q && (bmp == '0)) begin
            ended = 1'b1;
          end else begin
            acc = put_char(acc, {5'b0, bmp});
          end
        end
      end
      if (ended) begin
        if (!eoi_q) halted_d = 1'b1;
      end else if (eoi_q && hv_d) begin
        hv_d = 1'b0;
        acc  = put_char(acc, REPL_CP);
      end
      if (ended || eoi_q) begin
        fin      = 1'b1;
        kind     = (acc.room != '0) ? KIND_TERM : KIND_NOROOM;
        need     = acc.len + 18'd1;
        acc.cnt  = acc.cnt + 3'd1;
        active_d = 1'b0;
      end
    end
  end

  assign ld_o = '{load: in_valid_q, bytes: acc.bytes, cnt: acc.cnt, fin: fin,
                  kind: kind, need: need};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= '0;
      nul_q      <= 1'b0;
      in_valid_q <= 1'b0;
      room_q     <= '0;
      len_q      <= '0;
      hv_q       <= 1'b0;
      halted_q   <= 1'b0;
      active_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_CAPACITY: cap_q <= cfg_wdata_i;
          CFG_STOP_NUL: nul_q <= cfg_wdata_i[0];
          default:      ;
        endcase
      end
      if (unit_i.ready) in_valid_q <= unit_i.valid;
      if (advance) begin
        room_q   <= acc.room;
        len_q    <= acc.len;
        hv_q     <= hv_d;
        halted_q <= halted_d;
        active_q <= active_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (unit_i.ready && unit_i.valid) begin
      unit_q <= unit_i.code_unit;
      eoi_q  <= unit_i.end_of_input;
    end
    if (advance) hh_q <= hh_d;
  end

endmodule
`default_nettype wire

>>> src/u16u8_obuf.sv
`default_nettype none
module u16u8_obuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  u16u8_pkg::load_t ld_i,
  output logic             can_load_o,
  u16u8_out_if.source      byte_o
);
  import u16u8_pkg::*;

  logic [BUF_BYTES*BYTE_W-1:0] buf_q;
  logic [CNT_W-1:0]            rem_q;
  logic                        fin_q;
  kind_e                       kind_q;
  logic [LEN_W-1:0]            need_q;
  logic                        last;
  logic                        hs;
  logic                        load;

  assign last       = (rem_q == 3'd1);
  assign hs         = byte_o.valid && byte_o.ready;
  assign can_load_o = (rem_q == '0) || (last && byte_o.ready);
  assign load       = ld_i.load && can_load_o;

  assign byte_o.valid         = (rem_q != '0);
  assign byte_o.out_byte      = buf_q[BYTE_W-1:0];
  assign byte_o.item_kind     = (last && fin_q) ? kind_q : KIND_DATA;
  assign byte_o.needed_length = (last && fin_q) ? need_q : '0;
  assign byte_o.run_last      = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      fin_q <= 1'b0;
    end else if (load) begin
      rem_q <= ld_i.cnt;
      fin_q <= ld_i.fin;
    end else if (hs) begin
      rem_q <= rem_q - 3'd1;
    end
  end

  // shift the next byte down after each transaction
  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q  <= ld_i.bytes;
      kind_q <= ld_i.kind;
      need_q <= ld_i.need;
    end else if (hs) begin
      buf_q <= buf_q >> BYTE_W;
    end
  end

endmodule
`default_nettype wire

>>> src/utf16le_to_utf8_transcoder.sv
// A unit is registered at the input; its results then load the output buffer.
// Throughput: one result per cycle while the receiver is ready; a unit with
// zero or one result is accepted every cycle, one with more holds the input.
// Reset (rst_ni, asynchronous, active low) clears control state and the
// configuration registers; the first unit after reset starts a new string.
`default_nettype none
module utf16le_to_utf8_transcoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [u16u8_pkg::CAP_W-1:0] cfg_wdata_i,
  u16u8_in_if.sink                    unit_i,
  u16u8_out_if.source                 byte_o
);
  import u16u8_pkg::*;

  load_t ld;
  logic  can_load;

  u16u8_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .unit_i      (unit_i),
    .can_load_i  (can_load),
    .ld_o        (ld)
  );

  u16u8_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ld_i       (ld),
    .can_load_o (can_load),
    .byte_o     (byte_o)
  );

endmodule
`default_nettype wire

>>> src/u16u8_checker.sv
`default_nettype none
module u16u8_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [u16u8_pkg::BYTE_W-1:0] out_byte_i,
  input logic [u16u8_pkg::KIND_W-1:0] item_kind_i,
  input logic [u16u8_pkg::LEN_W-1:0]  needed_length_i,
  input logic                         run_last_i
);
  import u16u8_pkg::*;

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_byte_i) && $stable(item_kind_i)
      && $stable(needed_length_i) && $stable(run_last_i))
    else $error("result changed while stalled");

  a_data_no_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (item_kind_i == KIND_DATA) |-> (needed_length_i == '0))
    else $error("length reported on a data byte");

  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (item_kind_i != KIND_DATA) |->
      run_last_i && (out_byte_i == '0) && (needed_length_i != '0))
    else $error("final item malformed");

endmodule

bind utf16le_to_utf8_transcoder u16u8_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (byte_o.valid),
  .out_ready_i     (byte_o.ready),
  .out_byte_i      (byte_o.out_byte),
  .item_kind_i     (byte_o.item_kind),
  .needed_length_i (byte_o.needed_length),
  .run_last_i      (byte_o.run_last)
);
`default_nettype wire

>>> tb/utf16le_to_utf8_transcoder_checker.sv
`timescale 1ns / 100ps
module utf16le_to_utf8_transcoder_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [u16u8_pkg::CAP_W-1:0] cfg_wdata_i,
  u16u8_in_if                         unit_i,
  u16u8_out_if                        byte_i,
  output int                          errors_o,
  output int                          pending_o,
  output int                          checked_o,
  output int                          decoded_o
);
  import u16u8_pkg::*;

  localparam int LEN_SAT = 3 * MAX_STRING_UNITS;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    kind_e             kind;
    logic [LEN_W-1:0]  need;
    logic              run_last;
  } utf8_result_t;

  utf8_result_t utf8_expect_q[$];
  utf8_result_t step_buf[8];
  int           step_n;

  logic [CAP_W-1:0]  cap_q;
  logic              stop_nul_q;
  logic [UNIT_W-1:0] held_high;
  logic              held_valid;
  logic [CAP_W-1:0]  room_left;
  logic [LEN_W-1:0]  length_count;
  logic              halted;
  logic              in_string;

  function automatic void push_result(logic [BYTE_W-1:0] b, kind_e k,
                                      logic [LEN_W-1:0] need);
    step_buf[step_n] = '{out_byte: b, kind: k, need: need, run_last: 1'b0};
    step_n++;
  endfunction

  function automatic logic is_trail_unit(logic [UNIT_W-1:0] u);
    return u >= 16'hDC00 && u <= 16'hDFFF;
  endfunction

  function automatic logic [CP_W-1:0] scrub_bmp(logic [UNIT_W-1:0] u);
    if (is_trail_unit(u)) return REPL_CP;
    if (u[15:1] == 15'h7FFF) return REPL_CP;
    if (u >= 16'hFDD0 && u <= 16'hFDEF) return REPL_CP;
    return CP_W'(u);
  endfunction

  // Write the character only if it fits with room for the terminator;
  // otherwise treat the destination as full. The length counts it either way.
  function automatic void encode_char(logic [CP_W-1:0] cp);
    logic [BYTE_W-1:0] seq[4];
    int                len;
    int                total;
    if (cp < 21'h80) begin
      seq[0] = cp[7:0];
      len = 1;
    end else if (cp < 21'h800) begin
      seq[0] = {3'b110, cp[10:6]};
      seq[1] = {2'b10, cp[5:0]};
      len = 2;
    end else if (cp < 21'h10000) begin
      seq[0] = {4'b1110, cp[15:12]};
      seq[1] = {2'b10, cp[11:6]};
      seq[2] = {2'b10, cp[5:0]};
      len = 3;
    end else begin
      seq[0] = {5'b11110, cp[20:18]};
      seq[1] = {2'b10, cp[17:12]};
      seq[2] = {2'b10, cp[11:6]};
      seq[3] = {2'b10, cp[5:0]};
      len = 4;
    end
    if (len + 1 <= int'(room_left)) begin
      for (int i = 0; i < len; i++) push_result(seq[i], KIND_DATA, '0);
      room_left = room_left - CAP_W'(len);
    end else if (room_left > 1) begin
      room_left = CAP_W'(1);
    end
    total = int'(length_count) + len;
    if (total > LEN_SAT) total = LEN_SAT;
    length_count = LEN_W'(total);
  endfunction

  function automatic void finish_string();
    push_result('0, (room_left > 0) ? KIND_TERM : KIND_NOROOM, length_count + 1'b1);
    in_string = 1'b0;
  endfunction

  function automatic void decode_unit(logic [UNIT_W-1:0] u, logic eoi);
    logic [CP_W-1:0] cp;
    logic            fresh;
    logic            ended;
    step_n = 0;
    fresh = 1'b1;
    ended = 1'b0;
    // After a NUL in stop mode, drop units until the string is closed
    if (halted) begin
      if (eoi) halted = 1'b0;
      return;
    end
    decoded_o++;
    if (!in_string) begin
      room_left = cap_q;
      length_count = '0;
      held_high = '0;
      held_valid = 1'b0;
      in_string = 1'b1;
    end
    if (held_valid) begin
      held_valid = 1'b0;
      if (is_trail_unit(u)) begin
        cp = 21'h10000 + {held_high[9:0], u[9:0]};
        if (cp[15:1] == 15'h7FFF) cp = REPL_CP;
        encode_char(cp);
        fresh = 1'b0;
      end else begin
        // bad high surrogate: replace it, then decode this unit on its own
        encode_char(REPL_CP);
      end
      held_high = '0;
    end
    if (fresh) begin
      if (u >= 16'hD800 && u <= 16'hDBFF) begin
        held_high = u;
        held_valid = 1'b1;
      end else begin
        cp = scrub_bmp(u);
        if (stop_nul_q && cp == '0) begin
          finish_string();
          ended = 1'b1;
        end else begin
          encode_char(cp);
        end
      end
    end
    if (ended) begin
      if (!eoi) halted = 1'b1;
    end else if (eoi) begin
      if (held_valid) begin
        held_valid = 1'b0;
        held_high = '0;
        encode_char(REPL_CP);
      end
      finish_string();
    end
    for (int i = 0; i < step_n; i++) begin
      step_buf[i].run_last = (i == step_n - 1);
      utf8_expect_q.push_back(step_buf[i]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    utf8_result_t want;
    if (!rst_ni) begin
      cap_q = '0;
      stop_nul_q = 1'b0;
      held_high = '0;
      held_valid = 1'b0;
      room_left = '0;
      length_count = '0;
      halted = 1'b0;
      in_string = 1'b0;
      utf8_expect_q.delete();
      errors_o = 0;
      pending_o = 0;
      checked_o = 0;
      decoded_o = 0;
    end else begin
      if (unit_i.valid && unit_i.ready) decode_unit(unit_i.code_unit, unit_i.end_of_input);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CAPACITY: cap_q = cfg_wdata_i;
          CFG_STOP_NUL: stop_nul_q = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (byte_i.valid && byte_i.ready) begin
        checked_o++;
        if (utf8_expect_q.size() == 0) begin
          errors_o++;
          $error("unexpected result transaction: out_byte 0x%02h item_kind %0d",
                 byte_i.out_byte, byte_i.item_kind);
        end else begin
          want = utf8_expect_q.pop_front();
          if (byte_i.out_byte !== want.out_byte) begin
            errors_o++;
            $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, byte_i.out_byte);
          end
          if (byte_i.item_kind !== want.kind) begin
            errors_o++;
            $error("item_kind: expected %0d, got %0d", want.kind, byte_i.item_kind);
          end
          if (byte_i.needed_length !== want.need) begin
            errors_o++;
            $error("needed_length: expected %0d, got %0d", want.need, byte_i.needed_length);
          end
          if (byte_i.run_last !== want.run_last) begin
            errors_o++;
            $error("run_last: expected %0b, got %0b", want.run_last, byte_i.run_last);
          end
        end
      end
      pending_o = utf8_expect_q.size();
    end
  end

endmodule

>>> tb/utf16le_to_utf8_transcoder_tb.sv
`timescale 1ns / 100ps
module utf16le_to_utf8_transcoder_tb;
  import u16u8_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int LONG_HOLD    = 60;
  localparam int SETTLE_TAIL  = 4;
  localparam int RANDOM_UNITS = 120;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CAP_W-1:0] cfg_wdata_i;

  u16u8_in_if  unit_if ();
  u16u8_out_if byte_if ();

  int errors;
  int pending;
  int checked;
  int decoded;
  int units_sent;
  int strings_sent;
  int settings_used;
  int idle_cycles;
  bit quiet_source = 1'b0;
  bit quiet_sink = 1'b0;
  bit hold_sink_req = 1'b0;

  always #6 clk_i = ~clk_i;

  utf16le_to_utf8_transcoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .unit_i      (unit_if),
    .byte_o      (byte_if)
  );

  utf16le_to_utf8_transcoder_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .unit_i      (unit_if),
    .byte_i      (byte_if),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked),
    .decoded_o   (decoded)
  );

  // Leave valid high across back-to-back transactions; lower it only for a gap
  task automatic send_unit(input logic [UNIT_W-1:0] unit, input logic last);
    int gap;
    gap = quiet_source ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      unit_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    unit_if.valid <= 1'b1;
    unit_if.code_unit <= unit;
    unit_if.end_of_input <= last;
    @(posedge clk_i);
    while (!unit_if.ready) @(posedge clk_i);
    units_sent++;
    if (last) strings_sent++;
  endtask

  // Hold the sender until every predicted result has come out
  task automatic settle();
    unit_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_TAIL) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [CAP_W-1:0] capacity, input logic stop);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_CAPACITY;
    cfg_wdata_i <= capacity;
    @(posedge clk_i);
    cfg_idx_i <= CFG_STOP_NUL;
    cfg_wdata_i <= CAP_W'(stop);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [CAP_W-1:0] draw_capacity();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CAP_W'($urandom_range(1, 4));
      2: return CAP_W'($urandom_range(5, 24));
      3: return CAP_W'($urandom_range(25, 200));
      4: return '1;
      default: return CAP_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly valid text with random content; some lone surrogates,
  // non-characters, NULs and raw noise mixed in
  task automatic send_random_string(input int max_len);
    logic [UNIT_W-1:0] units[$];
    int                n;
    int                pick;
    n = $urandom_range(1, max_len);
    while (units.size() < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        units.push_back(UNIT_W'($urandom_range(1, 'h7F)));
      end else if (pick < 40) begin
        units.push_back(UNIT_W'($urandom_range('h80, 'h7FF)));
      end else if (pick < 58) begin
        units.push_back(UNIT_W'($urandom_range('h800, 'hD7FF)));
      end else if (pick < 62) begin
        units.push_back(UNIT_W'($urandom_range('hE000, 'hFFFF)));
      end else if (pick < 78) begin
        units.push_back(UNIT_W'($urandom_range('hD800, 'hDBFF)));
        units.push_back(UNIT_W'($urandom_range('hDC00, 'hDFFF)));
      end else if (pick < 82) begin
        if ($urandom_range(0, 1)) units.push_back({15'h7FFF, 1'($urandom_range(0, 1))});
        else units.push_back(UNIT_W'($urandom_range('hFDD0, 'hFDEF)));
      end else if (pick < 86) begin
        // pair that lands on a plane's last two code points
        units.push_back({6'b110110, 4'($urandom_range(0, 15)), 6'h3F});
        units.push_back({6'b110111, 9'h1FF, 1'($urandom_range(0, 1))});
      end else if (pick < 90) begin
        units.push_back(UNIT_W'($urandom_range('hDC00, 'hDFFF)));
      end else if (pick < 94) begin
        units.push_back(UNIT_W'($urandom_range('hD800, 'hDBFF)));
      end else if (pick < 97) begin
        units.push_back('0);
      end else begin
        units.push_back(UNIT_W'($urandom_range(0, 65535)));
      end
    end
    foreach (units[i]) send_unit(units[i], i == units.size() - 1);
  endtask

  initial begin : sink_side
    int stall;
    byte_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = quiet_sink ? 0 : $urandom_range(0, 9);
      if (hold_sink_req) begin
        hold_sink_req = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        byte_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      byte_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!byte_if.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (unit_if.valid && unit_if.ready) || (byte_if.valid && byte_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("utf16le_to_utf8_transcoder_tb: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int base;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_CAPACITY;
    cfg_wdata_i <= '0;
    unit_if.valid <= 1'b0;
    unit_if.code_unit <= '0;
    unit_if.end_of_input <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Encoding boundaries, non-characters and surrogate handling
    program_regs(16'd64, 1'b0);
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFE, 1'b0);
    send_unit(16'hFDD0, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hD801, 1'b0);
    send_unit(16'hD802, 1'b1);

    // Skipped character fills the destination; NUL stops, rest dropped
    settle();
    program_regs(16'd5, 1'b1);
    send_unit(16'h00E9, 1'b0);
    send_unit(16'h4E2D, 1'b0);
    send_unit(16'h0000, 1'b0);
    send_unit(16'h0042, 1'b0);
    send_unit(16'h0043, 1'b1);

    // Length only, then room for the terminator alone
    settle();
    program_regs(16'd0, 1'b1);
    send_unit(16'h0000, 1'b1);
    settle();
    program_regs(16'd1, 1'b0);
    send_unit(16'h20AC, 1'b1);

    // Change registers mid-string: stop mode applies at once, capacity later
    settle();
    program_regs(16'hFFFF, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0000, 1'b0);
    settle();
    program_regs(16'd3, 1'b1);
    send_unit(16'h0042, 1'b0);
    send_unit(16'h0000, 1'b1);
    send_unit(16'h00E9, 1'b1);

    // Fill the output while the receiver holds off
    settle();
    program_regs(16'hFFFF, 1'b0);
    quiet_source = 1'b1;
    hold_sink_req = 1'b1;
    for (int i = 0; i < 16; i++) send_unit(UNIT_W'($urandom_range('h800, 'hD7FF)), i == 15);
    quiet_source = 1'b0;

    base = units_sent;
    while (units_sent - base < RANDOM_UNITS) begin
      settle();
      program_regs(draw_capacity(), 1'($urandom_range(0, 1)));
      quiet_source = ($urandom_range(0, 3) == 0);
      quiet_sink = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 5)) send_random_string(12);
    end

    settle();
    $display("run covered %0d code units (%0d decoded) in %0d strings, %0d register settings",
             units_sent, decoded, strings_sent, settings_used);
    $display("checked %0d result transactions, with a long receiver stall and random gaps",
             checked);
    if (errors == 0 && pending == 0)
      $display("utf16le_to_utf8_transcoder_tb: clean");
    else
      $display("utf16le_to_utf8_transcoder_tb: errors");
    $finish;
  end

endmodule
